// ----- design/twg_pkg.sv -----
// Shared types and constants for the FFT twiddle factor generator.
package twg_pkg;

  // Field widths of the request and result words
  localparam int K_W    = 5;
  localparam int IDX_W  = 16;
  localparam int OUT_W  = 16;
  localparam int ANGLE_W = 30;

  // Request limits and packed table layout
  localparam logic [K_W-1:0] MIN_LOG2  = 5'd3;
  localparam logic [K_W-1:0] CFG_RESET = 5'd16;
  localparam int             ADDR_BIAS = 4;

  // Extra working bits below the output LSB, and output saturation bounds
  localparam int GUARD_BITS = 8;
  localparam int OUT_MAX    = 32767;
  localparam int OUT_MIN    = -32768;

  // CORDIC gain (inverse of the infinite-stage scale) in Q32
  localparam logic [63:0] GAIN_Q32   = 64'd2608131496;
  // 2*pi in Q29, used to turn a residual angle (turn units) into radians
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] STEP_ANGLE [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81,
    32'd41,        32'd20,        32'd10,        32'd5,
    32'd3,         32'd1,         32'd1,         32'd0
  };

  // Classified request word handed from front to back
  typedef struct packed {
    logic                err;
    logic                quad;
    logic [ANGLE_W-1:0]  angle;
    logic [IDX_W-1:0]    addr;
  } item_t;

  // Status between front and queue
  typedef struct packed {
    logic push;
    logic full;
  } queue_ctl_t;

endpackage

// ----- design/twg_front.sv -----
// Front end: accepts requests, checks range, folds the angle, computes the table address.
module twg_front #(
  parameter int LARGEST_LOG2 = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [twg_pkg::K_W-1:0]     stage_log2_size_i,
  input  logic [twg_pkg::IDX_W-1:0]   factor_index_i,
  input  logic                        cfg_we_i,
  input  logic [twg_pkg::K_W-1:0]     cfg_wdata_i,
  input  logic                        q_full_i,
  output twg_pkg::queue_ctl_t         q_ctl_o,
  output twg_pkg::item_t              item_o
);

  localparam logic [twg_pkg::K_W-1:0] MAX_K = twg_pkg::K_W'(LARGEST_LOG2);

  logic [twg_pkg::K_W-1:0] limit_q;
  logic [twg_pkg::K_W-1:0] limit_eff;
  logic                    valid_q;
  twg_pkg::item_t          item_q, item_d;
  logic                    accept, push;
  logic [47:0]             turn;
  logic [31:0]             addr_full;
  logic                    in_range;

  // Size limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= twg_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  // Classify the request
  always_comb begin
    limit_eff = (limit_q > MAX_K) ? MAX_K : limit_q;
    in_range  = (stage_log2_size_i >= twg_pkg::MIN_LOG2) &&
                (stage_log2_size_i <= limit_eff) &&
                ((factor_index_i >> (stage_log2_size_i - 5'd1)) == '0);
    // j / 2^k as a fraction of a full turn
    turn      = 48'(factor_index_i) << (6'd32 - {1'b0, stage_log2_size_i});
    addr_full = (32'd1 << (stage_log2_size_i - 5'd1)) - 32'(twg_pkg::ADDR_BIAS)
                + 32'(factor_index_i);
    item_d.err   = !in_range;
    item_d.quad  = turn[30];
    item_d.angle = turn[29:0];
    item_d.addr  = addr_full[twg_pkg::IDX_W-1:0];
  end

  assign push   = valid_q && !q_full_i;
  assign busy   = valid_q && q_full_i;
  assign accept = start && !busy;

  // Holding register in front of the queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (push) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  assign q_ctl_o.push = push;
  assign q_ctl_o.full = q_full_i;
  assign item_o       = item_q;

endmodule

// ----- design/twg_queue.sv -----
// Short queue that decouples the front end from the rotation pipeline.
module twg_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  twg_pkg::queue_ctl_t ctl_i,
  input  twg_pkg::item_t      item_i,
  output logic                full_o,
  output logic                pop_o,
  output twg_pkg::item_t      item_o
);

  localparam int DEPTH = twg_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);

  twg_pkg::item_t   mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q;
  logic             push, pop;

  // The back end never stalls: a stored word leaves in the next cycle
  assign pop    = (count_q != '0);
  assign push   = ctl_i.push && !ctl_i.full;
  assign full_o = (count_q == (PTR_W + 1)'(DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      unique case ({push, pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign pop_o  = pop;
  assign item_o = mem_q[rd_ptr_q];

endmodule

// ----- design/twg_back.sv -----
// Back end: pipelined CORDIC rotation, residual correction, rounding and saturation.
module twg_back #(
  parameter int FRACTION_BITS   = 15,
  parameter int ROTATION_STAGES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  twg_pkg::item_t                    item_i,
  output logic                              done_o,
  output logic signed [twg_pkg::OUT_W-1:0]  cos_part_o,
  output logic signed [twg_pkg::OUT_W-1:0]  sin_part_o,
  output logic [twg_pkg::IDX_W-1:0]         packed_address_o,
  output logic                              range_error_o
);

  localparam int N    = (ROTATION_STAGES > 32) ? 32 : ROTATION_STAGES;
  localparam int WB   = FRACTION_BITS + twg_pkg::GUARD_BITS;
  localparam int XW   = WB + 2;
  localparam int ZW   = 32;
  localparam int ZS_W = 25;     // residual angle after at least eight stages
  localparam int ZR_W = 26;     // residual angle in radians, Q30
  localparam int PX_W = XW + ZR_W;
  localparam int VW   = XW + 3;
  localparam int EW   = VW + 17;

  localparam logic [63:0] GAIN_FULL = (WB <= 32) ?
      (twg_pkg::GAIN_Q32 >> ((WB <= 32) ? (32 - WB) : 0)) :
      (twg_pkg::GAIN_Q32 << ((WB > 32) ? (WB - 32) : 0));
  localparam logic signed [XW-1:0] GAIN_INIT = signed'(GAIN_FULL[XW-1:0]);

  localparam logic signed [EW-1:0] ROUND_HALF = EW'(1 << (twg_pkg::GUARD_BITS - 1));
  localparam logic signed [EW-1:0] SAT_HI     = EW'(twg_pkg::OUT_MAX);
  localparam logic signed [EW-1:0] SAT_LO     = EW'(twg_pkg::OUT_MIN);

  typedef struct packed {
    logic                      err;
    logic                      quad;
    logic [twg_pkg::IDX_W-1:0] addr;
  } meta_t;

  // Round half up, drop the guard bits, clamp to the output range
  function automatic logic signed [twg_pkg::OUT_W-1:0] to_out(
    input logic signed [VW-1:0] v
  );
    logic signed [EW-1:0] e;
    e = EW'(v) + ROUND_HALF;
    e = e >>> twg_pkg::GUARD_BITS;
    if (e > SAT_HI) begin
      return twg_pkg::OUT_W'(twg_pkg::OUT_MAX);
    end else if (e < SAT_LO) begin
      return twg_pkg::OUT_W'(twg_pkg::OUT_MIN);
    end
    return e[twg_pkg::OUT_W-1:0];
  endfunction

  // Rotation pipeline registers, one set per micro-rotation
  logic signed [XW-1:0] x_q [1:N];
  logic signed [XW-1:0] y_q [1:N];
  logic signed [ZW-1:0] z_q [1:N];
  meta_t                m_q [1:N];
  logic [N:1]           v_q;

  for (genvar i = 0; i < N; i++) begin : g_rot
    logic signed [XW-1:0] xi, yi, dx, dy;
    logic signed [ZW-1:0] zi, ang;
    meta_t                mi;
    logic                 vi;

    if (i == 0) begin : g_first
      assign xi    = GAIN_INIT;
      assign yi    = '0;
      assign zi    = signed'(ZW'(item_i.angle));
      assign vi    = valid_i;
      assign mi    = '{err: item_i.err, quad: item_i.quad, addr: item_i.addr};
    end else begin : g_next
      assign xi = x_q[i];
      assign yi = y_q[i];
      assign zi = z_q[i];
      assign vi = v_q[i];
      assign mi = m_q[i];
    end

    assign dx  = yi >>> i;
    assign dy  = xi >>> i;
    assign ang = signed'(twg_pkg::STEP_ANGLE[i]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= vi;
      end
    end

    // Rotate toward zero residual angle
    always_ff @(posedge clk_i) begin
      if (!zi[ZW-1]) begin
        x_q[i+1] <= xi - dx;
        y_q[i+1] <= yi + dy;
        z_q[i+1] <= zi - ang;
      end else begin
        x_q[i+1] <= xi + dx;
        y_q[i+1] <= yi - dy;
        z_q[i+1] <= zi + ang;
      end
      m_q[i+1] <= mi;
    end
  end

  // Residual angle to radians
  logic signed [ZS_W-1:0]    zs;
  logic signed [ZS_W+32:0]   zprod;
  logic signed [ZS_W+32:0]   zshift;
  logic signed [ZR_W-1:0]    zr_q;
  logic signed [XW-1:0]      xa_q, ya_q;
  meta_t                     ma_q;
  logic                      va_q;

  assign zs     = z_q[N][ZS_W-1:0];
  assign zprod  = (ZS_W+33)'(zs) * signed'({1'b0, twg_pkg::TWO_PI_Q29});
  assign zshift = zprod >>> 31;

  always_ff @(posedge clk_i) begin
    zr_q <= zshift[ZR_W-1:0];
    xa_q <= x_q[N];
    ya_q <= y_q[N];
    ma_q <= m_q[N];
  end

  // First-order correction for the residual angle
  logic signed [PX_W-1:0] py, px, py_s, px_s;
  logic signed [XW:0]     x2_d, y2_d, x2_q, y2_q;
  meta_t                  mb_q;
  logic                   vb_q;

  assign py   = PX_W'(ya_q) * PX_W'(zr_q);
  assign px   = PX_W'(xa_q) * PX_W'(zr_q);
  assign py_s = py >>> 30;
  assign px_s = px >>> 30;
  assign x2_d = (XW+1)'(xa_q) - py_s[XW:0];
  assign y2_d = (XW+1)'(ya_q) + px_s[XW:0];

  always_ff @(posedge clk_i) begin
    x2_q <= x2_d;
    y2_q <= y2_d;
    mb_q <= ma_q;
  end

  // Quadrant unfold and output formatting
  logic signed [VW-1:0] cr, sr, sn;
  logic                 done_q;
  logic signed [twg_pkg::OUT_W-1:0] cos_q, sin_q;
  logic [twg_pkg::IDX_W-1:0]        addr_q;
  logic                             err_q;

  always_comb begin
    if (mb_q.quad) begin
      cr = -VW'(y2_q);
      sr = VW'(x2_q);
    end else begin
      cr = VW'(x2_q);
      sr = VW'(y2_q);
    end
    sn = -sr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q   <= 1'b0;
      vb_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      va_q   <= v_q[N];
      vb_q   <= va_q;
      done_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mb_q.err) begin
      cos_q  <= '0;
      sin_q  <= '0;
      addr_q <= '0;
    end else begin
      cos_q  <= to_out(cr);
      sin_q  <= to_out(sn);
      addr_q <= mb_q.addr;
    end
    err_q <= mb_q.err;
  end

  assign done_o           = done_q;
  assign cos_part_o       = cos_q;
  assign sin_part_o       = sin_q;
  assign packed_address_o = addr_q;
  assign range_error_o    = err_q;

endmodule

// ----- design/fft_twiddle_generator.sv -----
// Top level of the FFT twiddle factor generator.
//
// Usage: a request word (stage_log2_size_i = k, factor_index_i = j) is taken at a
// rising edge where start is high and busy is low. For 3 <= k <= limit and
// j < 2^(k-1) the result is cos and sin of -2*pi*j/2^k in Q1.15, rounded and
// saturated, plus the packed table address 2^(k-1)-4+j. Any other request
// returns range_error_o = 1 with all other fields zero.
// The limit is cfg_wdata_i as last written with cfg_we_i, clamped to LARGEST_LOG2;
// write it only while no request is in flight.
// Pipeline: done_o is high for one cycle per word; each accepted word passes in
// order through the front register, the queue, one stage per micro-rotation, the
// residual angle multiply, the correction multiply and the output register.
// Throughput: one word per cycle; the rotation pipeline advances every cycle,
// so busy stays low in normal use.
// The receiver cannot hold results off; each word is shown exactly once.
// Reset: the limit returns to 16 and all in-flight words are dropped.
module fft_twiddle_generator #(
  parameter int LARGEST_LOG2    = 16,
  parameter int FRACTION_BITS   = 15,
  parameter int ROTATION_STAGES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [twg_pkg::K_W-1:0]           stage_log2_size_i,
  input  logic [twg_pkg::IDX_W-1:0]         factor_index_i,
  input  logic                              cfg_we_i,
  input  logic [twg_pkg::K_W-1:0]           cfg_wdata_i,
  output logic                              done_o,
  output logic signed [twg_pkg::OUT_W-1:0]  cos_part_o,
  output logic signed [twg_pkg::OUT_W-1:0]  sin_part_o,
  output logic [twg_pkg::IDX_W-1:0]         packed_address_o,
  output logic                              range_error_o
);

  twg_pkg::queue_ctl_t q_ctl;
  twg_pkg::item_t      front_item, head_item;
  logic                q_full, q_pop;

  twg_front #(
    .LARGEST_LOG2(LARGEST_LOG2)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .stage_log2_size_i (stage_log2_size_i),
    .factor_index_i    (factor_index_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .q_full_i          (q_full),
    .q_ctl_o           (q_ctl),
    .item_o            (front_item)
  );

  twg_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (q_ctl),
    .item_i (front_item),
    .full_o (q_full),
    .pop_o  (q_pop),
    .item_o (head_item)
  );

  twg_back #(
    .FRACTION_BITS  (FRACTION_BITS),
    .ROTATION_STAGES(ROTATION_STAGES)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (q_pop),
    .item_i           (head_item),
    .done_o           (done_o),
    .cos_part_o       (cos_part_o),
    .sin_part_o       (sin_part_o),
    .packed_address_o (packed_address_o),
    .range_error_o    (range_error_o)
  );

endmodule

// ----- design/twg_checker.sv -----
// Port-level checks for the twiddle generator, bound to the top level.
module twg_checker #(
  parameter int LATENCY = 21
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic                              done_i,
  input logic signed [twg_pkg::OUT_W-1:0]  cos_part_i,
  input logic signed [twg_pkg::OUT_W-1:0]  sin_part_i,
  input logic [twg_pkg::IDX_W-1:0]         packed_address_i,
  input logic                              range_error_i
);

  // The pipeline drains every cycle, so the front never backs up
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  // Every accepted word comes out after the fixed latency
  a_accept_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY done_i)
    else $error("result missing");

  // No result appears without a matching request
  a_done_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_i |-> $past(start && !busy, LATENCY))
    else $error("spurious result");

  // An out-of-range word carries zeros
  a_error_zeros: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_i && range_error_i) |->
      (cos_part_i == '0) && (sin_part_i == '0) && (packed_address_i == '0))
    else $error("error word not cleared");

endmodule

bind fft_twiddle_generator twg_checker #(
  .LATENCY(((ROTATION_STAGES > 32) ? 32 : ROTATION_STAGES) + 5)
) u_twg_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .done_i           (done_o),
  .cos_part_i       (cos_part_o),
  .sin_part_i       (sin_part_o),
  .packed_address_i (packed_address_o),
  .range_error_i    (range_error_o)
);
